>>> sv/dqvs_pkg.sv
`timescale 1ns / 1ps

package dqvs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Request codes carried on in_req_type.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_CONTAINS   = 3'd4;
  localparam logic [2:0] REQ_REMOVE     = 3'd5;

  // Status codes carried on out_status.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_COMPARE = 3'd1,
    CELL_PUSHF   = 3'd2,
    CELL_PUSHB   = 3'd3,
    CELL_POPF    = 3'd4,
    CELL_POPB    = 3'd5,
    CELL_REMOVE  = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tail_flag;
  } cell_ctl_t;

endpackage

>>> sv/deque_with_value_search_core.sv
`timescale 1ns / 1ps

// Bounded double-ended queue with value search, built as a chain of cells.
// Cell 0 holds the front; occupied cells always form a run from cell 0.
// Input channel (in_valid / in_stall): one request per transaction, a push
// at either end, a pop at either end, a contains test or a remove of the
// first match seen from the front.
// Result channel (out_valid / out_stall): exactly one result transaction per
// request, with status, found flag, count and the front and back values.
// Requests do not overlap: a new request is taken only once the last one has loaded its result.
// A request passes through a compare step (every cell checks its entry
// against the key), an update step (the match flag ripples down the chain
// and the cells update together) and a report step that loads the output
// register.
// While a result waits under out_stall, the report step holds and no new
// request is taken; in_stall stays high until the block is idle again.
// Synchronous reset (rst_n low) empties the queue and drops any result.
module deque_with_value_search_core #(
  parameter int DEPTH      = dqvs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqvs_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [4:0]         out_count,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value
);
  import dqvs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = DATA_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SRCH = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_RPT  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    req_r;
  logic [DW-1:0] key_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          found_r, found_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic          out_found_r;
  logic [4:0]    out_count_r;
  logic [31:0]   out_front_r, out_back_r;

  cell_ctl_t     ctl;
  cell_op_t      exec_op;
  logic [DW-1:0] val_w  [DEPTH];
  logic [DW-1:0] tail_w [DEPTH];
  logic [DEPTH-1:0] vld_w;
  logic [DEPTH-1:0] seen_w;
  logic [DW-1:0] back_acc;
  logic [DW-1:0] front_w;
  logic          accept;
  logic          found_any;
  logic          is_full;
  logic          is_empty;
  logic          rpt_load;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign found_any = seen_w[DEPTH-1];
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign rpt_load  = (state_r == ST_RPT) && (!out_valid_r || !out_stall);

  // Decide the update and the status of the request in the update step.
  always_comb begin
    exec_op   = CELL_HOLD;
    stat_nxt  = STAT_OK;
    found_nxt = 1'b0;
    count_nxt = count_r;
    case (req_r)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (is_full) begin
          stat_nxt = STAT_FULL;
        end else begin
          exec_op   = (req_r == REQ_PUSH_FRONT) ? CELL_PUSHF : CELL_PUSHB;
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          exec_op   = (req_r == REQ_POP_FRONT) ? CELL_POPF : CELL_POPB;
          count_nxt = count_r - 1'b1;
        end
      end
      REQ_CONTAINS, REQ_REMOVE: begin
        if (is_empty) begin
          stat_nxt = STAT_EMPTY;
        end else if (!found_any) begin
          stat_nxt = STAT_NOTFOUND;
        end else begin
          found_nxt = 1'b1;
          if (req_r == REQ_REMOVE) begin
            exec_op   = CELL_REMOVE;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.tail_flag = (state_r == ST_RPT);
    case (state_r)
      ST_SRCH: ctl.op = CELL_COMPARE;
      ST_EXEC: ctl.op = exec_op;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SRCH;
      ST_SRCH: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RPT;
      ST_RPT:  if (rpt_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rpt_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DW-1:0] prev_v, next_v;
      logic          prev_ok, next_ok;
      if (gi == 0) begin : g_first
        assign prev_v  = key_r;
        assign prev_ok = 1'b1;
      end else begin : g_mid
        assign prev_v  = val_w[gi-1];
        assign prev_ok = vld_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_v  = '0;
        assign next_ok = 1'b0;
      end else begin : g_body
        assign next_v  = val_w[gi+1];
        assign next_ok = vld_w[gi+1];
      end
      dqvs_cell #(
        .DW(DW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_r),
        .prev_value (prev_v),
        .prev_valid (prev_ok),
        .next_value (next_v),
        .next_valid (next_ok),
        .seen_in    ((gi == 0) ? 1'b0 : seen_w[(gi == 0) ? 0 : gi-1]),
        .value      (val_w[gi]),
        .valid      (vld_w[gi]),
        .seen_out   (seen_w[gi]),
        .tail_value (tail_w[gi])
      );
    end
  endgenerate

  always_comb begin
    back_acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_acc = back_acc | tail_w[i];
    end
  end

  assign front_w = vld_w[0] ? val_w[0] : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      key_r <= DW'($unsigned(in_value));
    end
    if (state_r == ST_EXEC) begin
      stat_r  <= stat_nxt;
      found_r <= found_nxt;
    end
    if (rpt_load) begin
      out_status_r <= stat_r;
      out_found_r  <= found_r;
      out_count_r  <= 5'(count_r);
      out_front_r  <= 32'(front_w);
      out_back_r   <= 32'(back_acc);
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_count       = out_count_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count exceeds the depth");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(vld_w) == int'(count_r)))
    else $error("occupied cells disagree with the stored count");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (DEPTH'(vld_w + 1'b1) & vld_w) == '0)
    else $error("occupied cells do not form a run from the front");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SRCH))
    else $error("accepted transaction did not start a search");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_EMPTY)) |-> (out_count == 5'd0))
    else $error("empty status reported with a nonzero count");

endmodule

>>> sv/dqvs_cell.sv
`timescale 1ns / 1ps

module dqvs_cell #(
  parameter int DW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dqvs_pkg::cell_ctl_t ctl,
  input  logic [DW-1:0]     key,
  input  logic [DW-1:0]     prev_value,
  input  logic              prev_valid,
  input  logic [DW-1:0]     next_value,
  input  logic              next_valid,
  input  logic              seen_in,
  output logic [DW-1:0]     value,
  output logic              valid,
  output logic              seen_out,
  output logic [DW-1:0]     tail_value
);
  import dqvs_pkg::*;

  logic [DW-1:0] value_r, value_nxt;
  logic          valid_r, valid_nxt;
  logic          match_r, match_nxt;

  assign value    = value_r;
  assign valid    = valid_r;
  // The first match from the front enables the shift in this cell and all after it.
  assign seen_out = seen_in | match_r;
  // Only the last occupied cell drives the back value; the rest give zero.
  assign tail_value = (ctl.tail_flag && valid_r && !next_valid) ? value_r : '0;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    case (ctl.op)
      CELL_COMPARE: begin
        match_nxt = valid_r && (value_r == key);
      end
      CELL_PUSHF: begin
        value_nxt = prev_value;
        valid_nxt = prev_valid;
      end
      CELL_PUSHB: begin
        if (!valid_r && prev_valid) begin
          value_nxt = key;
          valid_nxt = 1'b1;
        end
      end
      CELL_POPF: begin
        value_nxt = next_value;
        valid_nxt = next_valid;
      end
      CELL_POPB: begin
        if (valid_r && !next_valid) begin
          valid_nxt = 1'b0;
        end
      end
      CELL_REMOVE: begin
        if (seen_out) begin
          value_nxt = next_value;
          valid_nxt = next_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

endmodule
